>>> hw/rtl/ntt_twiddle_generator_top_defines.svh
// ----------------------------------------------------------------------------
// NTT twiddle generator assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef NTT_TWIDDLE_GENERATOR_TOP_DEFINES_SVH
`define NTT_TWIDDLE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define NTG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ntg assertion failed");

// Next-cycle implication.
`define NTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ntg assertion failed");

`endif

>>> hw/rtl/ntg_pkg.sv
// ----------------------------------------------------------------------------
// NTT twiddle generator package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package ntg_pkg;

  typedef enum logic [2:0] {
    CFG_MODULUS = 3'd0,
    CFG_ROOT    = 3'd1,
    CFG_MONT    = 3'd2,
    CFG_QINV    = 3'd3,
    CFG_INV_N   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_MUL,
    ST_START,
    ST_WAIT,
    ST_QINV
  } back_state_e;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_SQ,
    OP_MONT,
    OP_INVN
  } op_e;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
  } rem_rsp_t;

  localparam logic [30:0] ModulusRst = 31'd8380417;
  localparam logic [30:0] RootRst    = 31'd1753;
  localparam logic [31:0] MontRst    = 32'hFFC01DFF;
  localparam logic [31:0] QinvRst    = 32'd58728449;
  localparam logic [31:0] InvNRst    = 32'd8347681;

endpackage

>>> hw/rtl/ntt_twiddle_generator_top.sv
// ----------------------------------------------------------------------------
// NTT twiddle generator top level
// Each request yields one centered twiddle factor zeta, scaled by the
// Montgomery factor (twice and then by inverse N when final_scale is set),
// plus the low 32 bits of zeta times q_inverse. Every modular multiply
// runs through the bit-serial remainder unit (64 steps plus multiply and
// fix-up); an item needs one squaring per significant exponent bit, one
// multiply per set bit and one or three scaling multiplies. A two-entry
// queue takes requests while the back end works, and the result register
// holds a finished beat until it is taken.
// ----------------------------------------------------------------------------
module ntt_twiddle_generator_top import ntg_pkg::*; #(
  parameter int EXPONENT_BITS = 9
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [EXPONENT_BITS-1:0] exponent_i,
  input  logic                     final_scale_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [30:0]              zeta_o,
  output logic [31:0]              zeta_times_qinv_o
);

  logic [30:0]              modulus_q, root_q;
  logic [31:0]              mont_q, qinv_q, invn_q;
  logic                     item_valid, item_fin, item_pop;
  logic [EXPONENT_BITS-1:0] item_exp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusRst;
      root_q    <= RootRst;
      mont_q    <= MontRst;
      qinv_q    <= QinvRst;
      invn_q    <= InvNRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODULUS: modulus_q <= cfg_data_i[30:0];
        CFG_ROOT:    root_q    <= cfg_data_i[30:0];
        CFG_MONT:    mont_q    <= cfg_data_i;
        CFG_QINV:    qinv_q    <= cfg_data_i;
        CFG_INV_N:   invn_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ntg_front #(.EXPONENT_BITS(EXPONENT_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .exponent_i    (exponent_i),
    .final_scale_i (final_scale_i),
    .item_valid_o  (item_valid),
    .item_exp_o    (item_exp),
    .item_fin_o    (item_fin),
    .item_pop_i    (item_pop)
  );

  ntg_back #(.EXPONENT_BITS(EXPONENT_BITS)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (item_valid),
    .item_exp_i        (item_exp),
    .item_fin_i        (item_fin),
    .item_pop_o        (item_pop),
    .modulus_i         (modulus_q),
    .root_i            (root_q),
    .mont_i            (mont_q),
    .qinv_i            (qinv_q),
    .invn_i            (invn_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .zeta_o            (zeta_o),
    .zeta_times_qinv_o (zeta_times_qinv_o)
  );

endmodule

>>> hw/rtl/ntg_front.sv
// ----------------------------------------------------------------------------
// NTT twiddle generator front end
// Accepts request beats into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ntg_front import ntg_pkg::*; #(
  parameter int EXPONENT_BITS = 9
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [EXPONENT_BITS-1:0] exponent_i,
  input  logic                     final_scale_i,
  output logic                     item_valid_o,
  output logic [EXPONENT_BITS-1:0] item_exp_o,
  output logic                     item_fin_o,
  input  logic                     item_pop_i
);

  logic [EXPONENT_BITS-1:0] exp_q [2];
  logic                     fin_q [2];
  logic                     wr_ptr_q, rd_ptr_q;
  logic [1:0]               cnt_q;
  logic                     push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_exp_o   = exp_q[rd_ptr_q];
  assign item_fin_o   = fin_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      exp_q[wr_ptr_q] <= exponent_i;
      fin_q[wr_ptr_q] <= final_scale_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

>>> hw/rtl/ntg_rem.sv
// ----------------------------------------------------------------------------
// NTT twiddle generator remainder unit
// Bit-serial centered reduction of a signed 64-bit product by the modulus.
// ----------------------------------------------------------------------------
module ntg_rem import ntg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] product_i,
  input  logic [30:0]        modulus_i,
  output rem_rsp_t           rsp_o
);

  logic [63:0]        mag_q;
  logic [31:0]        rem_q;
  logic               neg_q;
  logic               busy_q, done_q;
  logic [6:0]         cnt_q;
  logic [31:0]        rem_sh, rem_nx;
  logic signed [32:0] t, h, m, fix;

  assign rem_sh = {rem_q[30:0], mag_q[63]};
  assign rem_nx = (rem_sh >= {1'b0, modulus_i}) ? rem_sh - {1'b0, modulus_i} : rem_sh;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= product_i[63] ? 64'(-product_i) : product_i;
      neg_q <= product_i[63];
      rem_q <= 32'd0;
    end else if (busy_q) begin
      mag_q <= {mag_q[62:0], 1'b0};
      rem_q <= rem_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 7'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    m = $signed({2'b00, modulus_i});
    h = $signed({3'b000, modulus_i[30:1]});
    t = neg_q ? -$signed({1'b0, rem_q}) : $signed({1'b0, rem_q});
    if (t >= h)       fix = t - m;
    else if (t < -h)  fix = t + m;
    else              fix = t;
    rsp_o.done  = done_q;
    rsp_o.value = (modulus_i == 31'd0) ? 32'sd0 : fix[31:0];
  end

endmodule

>>> hw/rtl/ntg_back.sv
// ----------------------------------------------------------------------------
// NTT twiddle generator back end
// Sequences square-and-multiply, scaling and the qinv product per item.
// ----------------------------------------------------------------------------
module ntg_back import ntg_pkg::*; #(
  parameter int EXPONENT_BITS = 9
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  input  logic [EXPONENT_BITS-1:0] item_exp_i,
  input  logic                     item_fin_i,
  output logic                     item_pop_o,
  input  logic [30:0]              modulus_i,
  input  logic [30:0]              root_i,
  input  logic [31:0]              mont_i,
  input  logic [31:0]              qinv_i,
  input  logic [31:0]              invn_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [30:0]              zeta_o,
  output logic [31:0]              zeta_times_qinv_o
);

  back_state_e              state_q, state_d;
  op_e                      op_q, op_d;
  logic signed [31:0]       acc_q, acc_d, base_q, base_d;
  logic [EXPONENT_BITS-1:0] e_q, e_d;
  logic                     fin_q, fin_d, took_q, took_d;
  logic [1:0]               scnt_q, scnt_d;
  logic signed [63:0]       prod_q, prod_d;
  logic                     out_valid_q, out_valid_d;
  logic [30:0]              zeta_q, zeta_d;
  logic [31:0]              zq_q, zq_d;
  logic signed [31:0]       opa, opb;
  logic                     start, scale_more;
  rem_rsp_t                 rsp;

  ntg_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .product_i (prod_q),
    .modulus_i (modulus_i),
    .rsp_o     (rsp)
  );

  always_comb begin
    opa = (op_q == OP_SQ) ? base_q : acc_q;
    case (op_q)
      OP_MONT: opb = $signed(mont_i);
      OP_INVN: opb = $signed(invn_i);
      default: opb = base_q;
    endcase
  end

  assign scale_more = fin_q ? (scnt_q != 2'd3) : (scnt_q == 2'd0);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    acc_d       = acc_q;
    base_d      = base_q;
    e_d         = e_q;
    fin_d       = fin_q;
    took_d      = took_q;
    scnt_d      = scnt_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !out_ready_i;
    zeta_d      = zeta_q;
    zq_d        = zq_q;
    item_pop_o  = 1'b0;
    start       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          acc_d      = 32'sd1;
          base_d     = $signed({1'b0, root_i});
          e_d        = item_exp_i;
          fin_d      = item_fin_i;
          took_d     = 1'b0;
          scnt_d     = 2'd0;
          state_d    = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (e_q != '0) begin
          op_d    = (e_q[0] && !took_q) ? OP_ACC : OP_SQ;
          state_d = ST_MUL;
        end else if (scale_more) begin
          op_d    = (scnt_q == 2'd2) ? OP_INVN : OP_MONT;
          state_d = ST_MUL;
        end else begin
          state_d = ST_QINV;
        end
      end
      ST_MUL: begin
        prod_d  = opa * opb;
        state_d = ST_START;
      end
      ST_START: begin
        start   = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (rsp.done) begin
          case (op_q)
            OP_ACC: begin
              acc_d  = rsp.value;
              took_d = 1'b1;
            end
            OP_SQ: begin
              base_d = rsp.value;
              e_d    = e_q >> 1;
              took_d = 1'b0;
            end
            default: begin
              acc_d  = rsp.value;
              scnt_d = scnt_q + 2'd1;
            end
          endcase
          state_d = ST_NEXT;
        end
      end
      ST_QINV: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          zeta_d      = acc_q[30:0];
          zq_d        = 32'(acc_q * $signed(qinv_i));
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    e_q    <= e_d;
    fin_q  <= fin_d;
    took_q <= took_d;
    scnt_q <= scnt_d;
    prod_q <= prod_d;
    zeta_q <= zeta_d;
    zq_q   <= zq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign zeta_o            = zeta_q;
  assign zeta_times_qinv_o = zq_q;

endmodule

>>> hw/rtl/ntg_checker.sv
// ----------------------------------------------------------------------------
// NTT twiddle generator checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "ntt_twiddle_generator_top_defines.svh"

module ntg_checker import ntg_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     cfg_we_i,
  input logic [2:0]               cfg_index_i,
  input logic [31:0]              cfg_data_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [30:0]              zeta_o,
  input logic [31:0]              zeta_times_qinv_o
);

  logic [31:0] qinv_q;
  logic [31:0] zq_exp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qinv_q <= QinvRst;
    end else if (cfg_we_i && cfg_index_i == CFG_QINV) begin
      qinv_q <= cfg_data_i;
    end
  end

  assign zq_exp = 32'({zeta_o[30], zeta_o} * qinv_q);

  `NTG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(zeta_o) && $stable(zeta_times_qinv_o))
  `NTG_ASSERT_IMPL(a_out_drop, $fell(out_valid_o), $past(out_ready_i))
  `NTG_ASSERT_IMPL(a_zero_zq, out_valid_o && zeta_o == 31'd0, zeta_times_qinv_o == 32'd0)
  `NTG_ASSERT_IMPL(a_zq_match, out_valid_o, zeta_times_qinv_o == zq_exp)

endmodule

bind ntt_twiddle_generator_top ntg_checker u_ntg_checker (.*);
